@@ hw/rtl/tape_block_framer_assert.svh @@
// assertion macros for the tape block framer
`ifndef TAPE_BLOCK_FRAMER_ASSERT_SVH
`define TAPE_BLOCK_FRAMER_ASSERT_SVH
`ifndef SYNTH
`define TBF_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tbf assertion failed");
`define TBF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tbf assertion failed");
`else
`define TBF_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define TBF_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

@@ hw/rtl/tbf_pkg.sv @@
// shared types and constants for the tape block framer
package tbf_pkg;

   typedef enum logic [1:0] {
      OP_BEGIN  = 2'd0,
      OP_APPEND = 2'd1,
      OP_CLOSE  = 2'd2
   } op_type;

   localparam int LEADER_LEN  = 16;
   localparam int HDR_LEN     = 20;
   localparam int SYNC_A_POS  = 16;
   localparam int SYNC_B_POS  = 17;
   localparam int TYPE_POS    = 18;
   localparam int LEN_POS     = 19;
   localparam int LEN_BIAS    = 2;
   localparam logic [7:0] LEADER_BYTE = 8'h01;
   localparam logic [7:0] SYNC_A      = 8'h3c;
   localparam logic [7:0] SYNC_B      = 8'h5a;

   typedef struct packed {
      logic       valid;
      logic [7:0] count;
      logic [7:0] blk_type;
      logic [7:0] check;
   } emit_start_type;

endpackage

@@ hw/rtl/tape_block_framer.sv @@
// tape block framer top level: block state, store and emitter
// begin and append items are accepted at one item per cycle while req_ready is high
// close, or an append that fills the block, holds req_ready low while the frame of
// 21 + count bytes is sequenced, one frame byte per cycle unless rsp_ready stalls beats
// the first beat passes the sequencer, byte select stage, beat assembly and output register
// reset clears count, sum, type and the emitter; the payload store is not cleared
module tape_block_framer #(
   parameter int BLOCK_CAPACITY = 254,
   parameter int BEAT_BYTES     = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_operation,
   input  logic [7:0]  req_block_type,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_beat_data,
   output logic [3:0]  rsp_beat_count,
   output logic        rsp_beat_last
);
   import tbf_pkg::*;

   localparam int ADDR_W = (BLOCK_CAPACITY > 1) ? $clog2(BLOCK_CAPACITY) : 1;
   localparam int CNT_W  = $clog2(BLOCK_CAPACITY + 1);

   logic [CNT_W-1:0]  count_ff, count_in;
   logic [7:0]        sum_ff, sum_in;
   logic [7:0]        type_ff, type_in;
   logic              accept, busy, wr_en, rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [7:0]        rd_data, sum_next;
   emit_start_type    start;

   assign req_ready = ~busy;
   assign accept    = req_valid & req_ready;
   assign sum_next  = sum_ff + req_data_byte;

   always_comb begin
      count_in       = count_ff;
      sum_in         = sum_ff;
      type_in        = type_ff;
      wr_en          = 1'b0;
      start.valid    = 1'b0;
      start.count    = 8'(count_ff);
      start.blk_type = type_ff;
      start.check    = 8'd0 - sum_ff;
      if (accept) begin
         case (op_type'(req_operation))
            OP_BEGIN: begin
               type_in  = req_block_type;
               count_in = '0;
               sum_in   = '0;
            end
            OP_APPEND: begin
               wr_en = 1'b1;
               if (count_ff == CNT_W'(BLOCK_CAPACITY - 1)) begin
                  start.valid = 1'b1;
                  start.count = 8'(BLOCK_CAPACITY);
                  start.check = 8'd0 - sum_next;
                  count_in    = '0;
                  sum_in      = '0;
               end else begin
                  count_in = count_ff + CNT_W'(1);
                  sum_in   = sum_next;
               end
            end
            OP_CLOSE: begin
               start.valid = 1'b1;
               count_in    = '0;
               sum_in      = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         sum_ff   <= '0;
         type_ff  <= '0;
      end else begin
         count_ff <= count_in;
         sum_ff   <= sum_in;
         type_ff  <= type_in;
      end
   end

   tbf_store #(
      .DEPTH  (BLOCK_CAPACITY),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (ADDR_W'(count_ff)),
      .wr_data (req_data_byte),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   tbf_emit #(
      .BLOCK_CAPACITY (BLOCK_CAPACITY),
      .BEAT_BYTES     (BEAT_BYTES),
      .ADDR_W         (ADDR_W)
   ) u_emit (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .rd_en          (rd_en),
      .rd_addr        (rd_addr),
      .rd_data        (rd_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_beat_data  (rsp_beat_data),
      .rsp_beat_count (rsp_beat_count),
      .rsp_beat_last  (rsp_beat_last)
   );

endmodule

@@ hw/rtl/tbf_store.sv @@
// payload byte memory, one write port and one registered read port
module tbf_store #(
   parameter int DEPTH  = 254,
   parameter int ADDR_W = 8
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]        rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/tbf_emit.sv @@
// block emitter: frame byte sequencer, beat assembly and output register
`include "tape_block_framer_assert.svh"
module tbf_emit #(
   parameter int BLOCK_CAPACITY = 254,
   parameter int BEAT_BYTES     = 8,
   parameter int ADDR_W         = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  tbf_pkg::emit_start_type start,
   output logic                    busy,
   output logic                    rd_en,
   output logic [ADDR_W-1:0]       rd_addr,
   input  logic [7:0]              rd_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [63:0]             rsp_beat_data,
   output logic [3:0]              rsp_beat_count,
   output logic                    rsp_beat_last
);
   import tbf_pkg::*;

   localparam int POS_W = $clog2(BLOCK_CAPACITY + HDR_LEN + 2);

   // sequencer stage
   logic             a_active_ff, a_active_in;
   logic [POS_W-1:0] a_pos_ff, a_pos_in;
   logic [7:0]       a_cnt_ff, a_cnt_in;
   logic [7:0]       a_type_ff, a_type_in;
   logic [7:0]       a_chk_ff, a_chk_in;
   logic             a_end, a_mem, a_go;
   logic [7:0]       a_byte;

   // byte select stage
   logic             b_valid_ff, b_mem_ff, b_last_ff;
   logic [7:0]       b_byte_ff;
   logic             b_adv, b_take;
   logic [7:0]       b_value;

   // beat assembly
   logic [63:0]      asm_data_ff, asm_data_in;
   logic [3:0]       asm_cnt_ff, asm_cnt_in;
   logic             asm_done_ff, asm_done_in;
   logic             asm_last_ff, asm_last_in;
   logic             asm_free, move;
   logic [3:0]       new_cnt;

   // output register
   logic             rsp_valid_ff;
   logic [63:0]      rsp_data_ff;
   logic [3:0]       rsp_count_ff;
   logic             rsp_last_ff;

   assign a_end = (a_pos_ff == POS_W'(HDR_LEN) + POS_W'(a_cnt_ff));

   always_comb begin
      a_mem  = 1'b0;
      a_byte = 8'h00;
      if (a_pos_ff < POS_W'(LEADER_LEN)) begin
         a_byte = LEADER_BYTE;
      end else if (a_pos_ff == POS_W'(SYNC_A_POS)) begin
         a_byte = SYNC_A;
      end else if (a_pos_ff == POS_W'(SYNC_B_POS)) begin
         a_byte = SYNC_B;
      end else if (a_pos_ff == POS_W'(TYPE_POS)) begin
         a_byte = a_type_ff;
      end else if (a_pos_ff == POS_W'(LEN_POS)) begin
         a_byte = a_cnt_ff + 8'(LEN_BIAS);
      end else if (a_end) begin
         a_byte = a_chk_ff;
      end else begin
         a_mem = 1'b1;
      end
   end

   assign move     = asm_done_ff & (~rsp_valid_ff | rsp_ready);
   assign asm_free = ~asm_done_ff | move;
   assign b_adv    = ~b_valid_ff | asm_free;
   assign b_take   = b_valid_ff & asm_free;
   assign a_go     = a_active_ff & b_adv;
   assign rd_en    = a_go & a_mem;
   assign rd_addr  = ADDR_W'(a_pos_ff - POS_W'(HDR_LEN));
   assign busy     = a_active_ff;
   assign b_value  = b_mem_ff ? rd_data : b_byte_ff;

   always_comb begin
      a_active_in = a_active_ff;
      a_pos_in    = a_pos_ff;
      a_cnt_in    = a_cnt_ff;
      a_type_in   = a_type_ff;
      a_chk_in    = a_chk_ff;
      if (start.valid) begin
         a_active_in = 1'b1;
         a_pos_in    = '0;
         a_cnt_in    = start.count;
         a_type_in   = start.blk_type;
         a_chk_in    = start.check;
      end else if (a_go) begin
         a_pos_in = a_pos_ff + POS_W'(1);
         if (a_end) begin
            a_active_in = 1'b0;
         end
      end
   end

   always_comb begin
      asm_data_in = asm_data_ff;
      asm_cnt_in  = asm_cnt_ff;
      asm_done_in = asm_done_ff;
      asm_last_in = asm_last_ff;
      new_cnt     = asm_cnt_ff + 4'd1;
      if (b_take) begin
         // a pending beat leaves this cycle, so start a fresh one
         if (asm_done_ff) begin
            asm_data_in = '0;
            asm_cnt_in  = '0;
         end
         for (int lane = 0; lane < BEAT_BYTES; lane++) begin
            if (asm_cnt_in == 4'(lane)) begin
               asm_data_in[lane*8 +: 8] = b_value;
            end
         end
         new_cnt     = asm_cnt_in + 4'd1;
         asm_cnt_in  = new_cnt;
         asm_done_in = (new_cnt == 4'(BEAT_BYTES)) | b_last_ff;
         asm_last_in = b_last_ff;
      end else if (move) begin
         asm_data_in = '0;
         asm_cnt_in  = '0;
         asm_done_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_active_ff  <= 1'b0;
         b_valid_ff   <= 1'b0;
         asm_data_ff  <= '0;
         asm_cnt_ff   <= '0;
         asm_done_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         a_active_ff <= a_active_in;
         if (b_adv) begin
            b_valid_ff <= a_go;
         end
         asm_data_ff <= asm_data_in;
         asm_cnt_ff  <= asm_cnt_in;
         asm_done_ff <= asm_done_in;
         if (move) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      a_pos_ff    <= a_pos_in;
      a_cnt_ff    <= a_cnt_in;
      a_type_ff   <= a_type_in;
      a_chk_ff    <= a_chk_in;
      asm_last_ff <= asm_last_in;
      if (b_adv) begin
         b_mem_ff  <= a_mem;
         b_byte_ff <= a_byte;
         b_last_ff <= a_end;
      end
      if (move) begin
         rsp_data_ff  <= asm_data_ff;
         rsp_count_ff <= asm_cnt_ff;
         rsp_last_ff  <= asm_last_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_beat_data  = rsp_data_ff;
   assign rsp_beat_count = rsp_count_ff;
   assign rsp_beat_last  = rsp_last_ff;

   `TBF_ASSERT_IMPL(a_start_idle, clock, reset, start.valid, !a_active_ff)
   `TBF_ASSERT_NEXT(a_start_runs, clock, reset, start.valid, a_active_ff)
   `TBF_ASSERT_IMPL(a_beat_range, clock, reset, rsp_valid_ff, rsp_count_ff - 4'd1 < 4'(BEAT_BYTES))
   `TBF_ASSERT_IMPL(a_read_data, clock, reset, rd_en, a_pos_ff >= POS_W'(HDR_LEN))

endmodule

@@ tb/tbf_checker.sv @@
// checker for the tape block framer: predicts the emitted beats and compares them
module tbf_checker #(
   parameter int BLOCK_CAPACITY = 254,
   parameter int BEAT_BYTES     = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_operation,
   input  logic [7:0]  req_block_type,
   input  logic [7:0]  req_data_byte,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [63:0] rsp_beat_data,
   input  logic [3:0]  rsp_beat_count,
   input  logic        rsp_beat_last,
   output int          error_count,
   output int          beats_pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import tbf_pkg::*;

   typedef struct packed {
      logic [63:0] data;
      logic [3:0]  count;
      logic        last;
   } tape_beat_t;

   logic [7:0] held_bytes [BLOCK_CAPACITY];
   logic [7:0] held_count;
   logic [7:0] held_sum;
   logic [7:0] held_type;
   tape_beat_t expected_beats [$];
   int errors;

   initial begin
      errors = 0;
   end

   task automatic queue_block_beats();
      logic [7:0] frame [$];
      tape_beat_t beat;
      int k;
      frame = {};
      repeat (LEADER_LEN) frame.push_back(LEADER_BYTE);
      frame.push_back(SYNC_A);
      frame.push_back(SYNC_B);
      frame.push_back(held_type);
      frame.push_back(8'(held_count + 8'(LEN_BIAS)));
      for (int i = 0; i < held_count; i++) frame.push_back(held_bytes[i]);
      frame.push_back(8'(8'd0 - held_sum));
      beat = '0;
      k = 0;
      foreach (frame[i]) begin
         beat.data[8*k +: 8] = frame[i];
         k++;
         if (k == BEAT_BYTES || i == frame.size() - 1) begin
            beat.count = 4'(k);
            beat.last = (i == frame.size() - 1);
            expected_beats.push_back(beat);
            beat = '0;
            k = 0;
         end
      end
      held_count = '0;
      held_sum = '0;
   endtask

   task automatic predict_item(input logic [1:0] op, input logic [7:0] kind,
                               input logic [7:0] value);
      case (op)
         OP_BEGIN: begin
            held_type = kind;
            held_count = '0;
            held_sum = '0;
         end
         OP_APPEND: begin
            if (held_count < BLOCK_CAPACITY) begin
               held_bytes[held_count] = value;
               held_count = held_count + 8'd1;
               held_sum = held_sum + value;
            end
            if (held_count >= BLOCK_CAPACITY) queue_block_beats();
         end
         OP_CLOSE: queue_block_beats();
         default: ;
      endcase
   endtask

   always @(posedge clock) begin : watch
      tape_beat_t got;
      tape_beat_t want;
      if (reset) begin
         held_count = '0;
         held_sum = '0;
         held_type = '0;
         expected_beats = {};
      end else begin
         if (req_valid && req_ready)
            predict_item(req_operation, req_block_type, req_data_byte);
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_beat_data, rsp_beat_count, rsp_beat_last};
            if (expected_beats.size() == 0) begin
               if (errors < 10)
                  $display("unexpected beat: data %h count %0d last %b",
                           got.data, got.count, got.last);
               errors++;
            end else begin
               want = expected_beats.pop_front();
               if (got.data !== want.data || got.count !== want.count ||
                   got.last !== want.last) begin
                  if (errors < 10)
                     $display("beat mismatch: expected %h/%0d/%b got %h/%0d/%b",
                              want.data, want.count, want.last,
                              got.data, got.count, got.last);
                  errors++;
               end
            end
         end
      end
      error_count <= errors;
      beats_pending <= expected_beats.size();
   end

endmodule

@@ tb/tb.sv @@
// testbench top for the tape block framer: clock, reset, stimulus and verdict
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import tbf_pkg::*;

   localparam int BLOCK_CAPACITY = 254;
   localparam int BEAT_BYTES     = 8;
   localparam int RANDOM_ITEMS   = 180;
   localparam int LONG_STALL     = 600;
   localparam int DRAIN_CYCLES   = 300;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_operation = OP_BEGIN;
   logic [7:0]  req_block_type = '0;
   logic [7:0]  req_data_byte = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [63:0] rsp_beat_data;
   logic [3:0]  rsp_beat_count;
   logic        rsp_beat_last;

   int error_count;
   int beats_pending;
   int items_sent = 0;
   bit sender_fast = 1'b0;
   bit stall_request = 1'b0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   tape_block_framer #(
      .BLOCK_CAPACITY(BLOCK_CAPACITY),
      .BEAT_BYTES(BEAT_BYTES)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_operation(req_operation),
      .req_block_type(req_block_type),
      .req_data_byte(req_data_byte),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_beat_data(rsp_beat_data),
      .rsp_beat_count(rsp_beat_count),
      .rsp_beat_last(rsp_beat_last)
   );

   tbf_checker #(
      .BLOCK_CAPACITY(BLOCK_CAPACITY),
      .BEAT_BYTES(BEAT_BYTES)
   ) i_checker (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_operation(req_operation),
      .req_block_type(req_block_type),
      .req_data_byte(req_data_byte),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_beat_data(rsp_beat_data),
      .rsp_beat_count(rsp_beat_count),
      .rsp_beat_last(rsp_beat_last),
      .error_count(error_count),
      .beats_pending(beats_pending)
   );

   task automatic send_item(input logic [1:0] op, input logic [7:0] kind,
                            input logic [7:0] value);
      int gap;
      gap = sender_fast ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_block_type <= kind;
      req_data_byte <= value;
      do @(posedge clock); while (!req_ready);
      if (op != OP_UNUSED) items_sent++;
   endtask

   // the pending count is a registered checker output and settles after the last accepted item
   task automatic wait_for_drain();
      @(posedge clock);
      while (beats_pending != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] pick_type();
      case ($urandom_range(0, 3))
         0: return 8'h00;
         1: return 8'h01;
         2: return 8'hff;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic send_block();
      int n;
      send_item(OP_BEGIN, pick_type(), 8'($urandom));
      n = $urandom_range(0, 16);
      repeat (n) send_item(OP_APPEND, 8'($urandom), 8'($urandom_range(0, 255)));
      // a missing close leaves the bytes to be dropped by the next begin
      if ($urandom_range(0, 7) != 0) send_item(OP_CLOSE, 8'($urandom), 8'($urandom));
   endtask

   // receiver: random gaps between beats, bursts without gaps, one long hold-off
   initial begin : receiver
      int wait_cycles;
      int beat_no;
      bit rsp_fast;
      bit stall_done;
      beat_no = 0;
      rsp_fast = 1'b0;
      stall_done = 1'b0;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         if (beat_no % 20 == 0) rsp_fast = ($urandom_range(0, 3) == 0);
         if (stall_request && !stall_done) begin
            rsp_ready <= 1'b0;
            repeat (LONG_STALL) @(posedge clock);
            stall_done = 1'b1;
         end
         wait_cycles = rsp_fast ? 0 : $urandom_range(0, 13);
         if (wait_cycles > 0) begin
            rsp_ready <= 1'b0;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         beat_no++;
      end
   end

   initial begin
      #50_000_000;
      $display("tb: failure");
      $finish;
   end

   initial begin : stimulus
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // close and append before any begin use type zero
      send_item(OP_CLOSE, 8'h00, 8'h00);
      send_item(OP_APPEND, 8'h00, 8'h00);
      send_item(OP_APPEND, 8'hff, 8'hff);
      send_item(OP_CLOSE, 8'hff, 8'hff);
      send_item(OP_UNUSED, 8'hff, 8'hff);
      send_item(OP_BEGIN, 8'hff, 8'h00);
      send_item(OP_CLOSE, 8'h00, 8'h00);
      send_item(OP_BEGIN, 8'h00, 8'hff);
      send_item(OP_APPEND, 8'h00, 8'h80);
      send_item(OP_APPEND, 8'h00, 8'h7f);
      send_item(OP_APPEND, 8'h00, 8'h01);
      // begin drops the buffered bytes
      send_item(OP_BEGIN, 8'h01, 8'h00);
      send_item(OP_APPEND, 8'h00, 8'haa);
      send_item(OP_APPEND, 8'h00, 8'h55);
      send_item(OP_CLOSE, 8'h00, 8'h00);
      send_item(OP_CLOSE, 8'h00, 8'h00);
      send_item(OP_UNUSED, 8'h00, 8'h00);
      send_item(OP_BEGIN, 8'h5a, 8'h00);
      send_item(OP_APPEND, 8'h00, 8'hff);
      send_item(OP_APPEND, 8'h00, 8'hff);
      send_item(OP_APPEND, 8'h00, 8'hff);
      send_item(OP_APPEND, 8'h00, 8'h01);
      send_item(OP_CLOSE, 8'h00, 8'h00);

      // full block under a long receiver hold-off, then more bytes after the auto emit
      req_valid <= 1'b0;
      wait_for_drain();
      stall_request = 1'b1;
      sender_fast = 1'b1;
      send_item(OP_BEGIN, 8'h01, 8'h00);
      repeat (BLOCK_CAPACITY + 2) send_item(OP_APPEND, 8'h00, 8'($urandom_range(0, 255)));
      send_item(OP_CLOSE, 8'h00, 8'h00);

      items_sent = 0;
      while (items_sent < RANDOM_ITEMS) begin
         sender_fast = ($urandom_range(0, 4) == 0);
         case ($urandom_range(0, 11))
            0: send_item(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom));
            1: send_item(OP_UNUSED, 8'($urandom), 8'($urandom));
            2: begin
               req_valid <= 1'b0;
               wait_for_drain();
               send_block();
            end
            default: send_block();
         endcase
      end

      req_valid <= 1'b0;
      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && beats_pending == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
